@@ rtl/core/s2ib_pkg.sv @@
package s2ib_pkg;

   // request opcodes
   localparam logic [1:0] OP_SPI_BYTE = 2'd0;
   localparam logic [1:0] OP_CS_CHANGE = 2'd1;
   localparam logic [1:0] OP_I2C_BYTE = 2'd2;

   // frame commands
   localparam logic [7:0] CMD_WR_N = 8'h00;
   localparam logic [7:0] CMD_RD_N = 8'h01;
   localparam logic [7:0] CMD_RD_BUF = 8'h06;
   localparam logic [7:0] CMD_WR_REG = 8'h20;
   localparam logic [7:0] CMD_RD_REG = 8'h21;
   localparam logic [7:0] CMD_NONE = 8'hff;

   localparam logic [7:0] ANSWER_IDLE = 8'hff;

   // response kinds
   localparam logic OUT_SPI = 1'b0;
   localparam logic OUT_I2C = 1'b1;

   // i2c message kinds
   localparam logic [2:0] I2C_START = 3'd0;
   localparam logic [2:0] I2C_ADR = 3'd1;
   localparam logic [2:0] I2C_DATA = 3'd2;
   localparam logic [2:0] I2C_CLK = 3'd3;
   localparam logic [2:0] I2C_STOP = 3'd4;

   // transmit store layout
   localparam logic [7:0] TX_LEN_SLOT = 8'd1;
   localparam logic [7:0] TX_ADDR_SLOT = 8'd2;
   localparam logic [7:0] TX_DATA_SLOT = 8'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SPI_ANS,
      ST_LEN,
      ST_START,
      ST_ADDR,
      ST_BODY,
      ST_STOP
   } state_type;

endpackage

@@ rtl/core/spi_to_i2c_bridge_controller_unit.sv @@
// spi byte: decoded in ST_DECODE, answered on rsp_ in ST_SPI_ANS, then ready for a new request
// chip select low, returned i2c byte, spi byte while deselected: no response, idle after ST_DECODE
// chip select high with write-n/read-n: start, addr, one message per byte, stop;
//   busy through ST_LEN to ST_STOP, set by the single transmit store read port and the burst counter
// responses cannot be stalled; reset is synchronous and clears control state, registers
//   and the per-entry valid bits of both stores, so no clearing pass is needed
module spi_to_i2c_bridge_controller_unit #(
   parameter int BUFFER_DEPTH = 60,
   parameter int REGISTER_COUNT = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_data_byte,
   input  logic       req_cs_level,
   output logic       rsp_valid,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_spi_answer,
   output logic [2:0] rsp_i2c_kind,
   output logic [7:0] rsp_i2c_byte,
   output logic       rsp_last
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int RIDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);
   localparam logic [7:0] REGS_B = 8'(REGISTER_COUNT);
   localparam logic [7:0] LEN_WR_MAX = 8'(BUFFER_DEPTH - 3);
   localparam logic [7:0] TX_DATA_NEXT = s2ib_pkg::TX_DATA_SLOT + 8'd1;

   s2ib_pkg::state_type state_ff, state_in;

   logic [1:0] op_ff;
   logic [7:0] data_ff;
   logic       cs_ff;

   logic             desel_ff, desel_in;
   logic [7:0]       step_ff, step_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [2:0]       regptr_ff, regptr_in;
   logic [CNT_W-1:0] rxptr_ff, rxptr_in;
   logic [7:0]       regs_ff [REGISTER_COUNT];
   logic [7:0]       regs_in [REGISTER_COUNT];
   logic [7:0]       ans_ff, ans_in;
   logic             ans_rx_ff, ans_rx_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       addr_ff, addr_in;
   logic             rd_burst_ff, rd_burst_in;

   // transmit store
   logic [7:0]              tx_mem [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] tx_vld_ff;
   logic                    tx_we, tx_re;
   logic [AW-1:0]           tx_waddr, tx_raddr;
   logic [7:0]              tx_q_ff;
   logic                    tx_qv_ff;
   logic [7:0]              tx_rd;

   // receive store
   logic [7:0]              rx_mem [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] rx_vld_ff;
   logic                    rx_we, rx_re;
   logic [AW-1:0]           rx_waddr, rx_raddr;
   logic [7:0]              rx_q_ff;
   logic                    rx_qv_ff;
   logic [7:0]              rx_rd;

   logic [7:0]       cmd_cur;
   logic [7:0]       step_m1;
   logic [7:0]       body_idx;
   logic [7:0]       len_max;
   logic [CNT_W-1:0] cnt_nxt;
   logic             burst_go;

   assign tx_rd = tx_qv_ff ? tx_q_ff : 8'd0;
   assign rx_rd = rx_qv_ff ? rx_q_ff : 8'd0;
   assign cmd_cur = (step_ff == 8'd0) ? data_ff : cmd_ff;
   assign step_m1 = step_ff - 8'd1;
   assign body_idx = 8'(cnt_ff) + TX_DATA_NEXT;
   assign len_max = rd_burst_ff ? DEPTH_B : LEN_WR_MAX;
   assign cnt_nxt = cnt_ff + 1'b1;
   assign burst_go = (op_ff == s2ib_pkg::OP_CS_CHANGE) && cs_ff &&
                     ((cmd_ff == s2ib_pkg::CMD_WR_N) || (cmd_ff == s2ib_pkg::CMD_RD_N));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         s2ib_pkg::ST_IDLE: begin
            if (start) begin
               state_in = s2ib_pkg::ST_DECODE;
            end
         end
         s2ib_pkg::ST_DECODE: begin
            if ((op_ff == s2ib_pkg::OP_SPI_BYTE) && !desel_ff) begin
               state_in = s2ib_pkg::ST_SPI_ANS;
            end else if (burst_go) begin
               state_in = s2ib_pkg::ST_LEN;
            end else begin
               state_in = s2ib_pkg::ST_IDLE;
            end
         end
         s2ib_pkg::ST_SPI_ANS: state_in = s2ib_pkg::ST_IDLE;
         s2ib_pkg::ST_LEN:     state_in = s2ib_pkg::ST_START;
         s2ib_pkg::ST_START:   state_in = s2ib_pkg::ST_ADDR;
         s2ib_pkg::ST_ADDR: begin
            state_in = (len_ff == '0) ? s2ib_pkg::ST_STOP : s2ib_pkg::ST_BODY;
         end
         s2ib_pkg::ST_BODY: begin
            if (cnt_nxt == len_ff) begin
               state_in = s2ib_pkg::ST_STOP;
            end
         end
         s2ib_pkg::ST_STOP: state_in = s2ib_pkg::ST_IDLE;
         default:           state_in = s2ib_pkg::ST_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      desel_in = desel_ff;
      step_in = step_ff;
      cmd_in = cmd_ff;
      regptr_in = regptr_ff;
      rxptr_in = rxptr_ff;
      regs_in = regs_ff;
      ans_in = ans_ff;
      ans_rx_in = ans_rx_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      addr_in = addr_ff;
      rd_burst_in = rd_burst_ff;
      tx_we = 1'b0;
      tx_waddr = step_ff[AW-1:0];
      tx_re = 1'b0;
      tx_raddr = s2ib_pkg::TX_LEN_SLOT[AW-1:0];
      rx_we = 1'b0;
      rx_waddr = rxptr_ff[AW-1:0];
      rx_re = 1'b0;
      rx_raddr = step_m1[AW-1:0];

      unique case (state_ff)
         s2ib_pkg::ST_DECODE: begin
            if (op_ff == s2ib_pkg::OP_SPI_BYTE) begin
               if (desel_ff) begin
                  step_in = 8'd0;
               end else begin
                  cmd_in = cmd_cur;
                  ans_in = s2ib_pkg::ANSWER_IDLE;
                  ans_rx_in = 1'b0;
                  if (step_ff != 8'hff) begin
                     step_in = step_ff + 8'd1;
                  end
                  unique case (cmd_cur)
                     s2ib_pkg::CMD_WR_N, s2ib_pkg::CMD_RD_N: begin
                        tx_we = (step_ff < DEPTH_B);
                     end
                     s2ib_pkg::CMD_RD_BUF: begin
                        if ((step_ff != 8'd0) && (step_ff <= DEPTH_B)) begin
                           rx_re = 1'b1;
                           ans_rx_in = 1'b1;
                        end
                     end
                     s2ib_pkg::CMD_WR_REG, s2ib_pkg::CMD_RD_REG: begin
                        if (step_ff == 8'd1) begin
                           if (data_ff < REGS_B) begin
                              regptr_in = data_ff[2:0];
                           end
                        end else if ((step_ff == 8'd2) && (8'(regptr_ff) < REGS_B)) begin
                           if (cmd_cur == s2ib_pkg::CMD_WR_REG) begin
                              regs_in[regptr_ff[RIDX_W-1:0]] = data_ff;
                           end else begin
                              ans_in = regs_ff[regptr_ff[RIDX_W-1:0]];
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end else if (op_ff == s2ib_pkg::OP_CS_CHANGE) begin
               desel_in = cs_ff;
               step_in = 8'd0;
               if (!cs_ff) begin
                  cmd_in = s2ib_pkg::CMD_NONE;
               end else if (burst_go) begin
                  rd_burst_in = (cmd_ff == s2ib_pkg::CMD_RD_N);
                  tx_re = 1'b1;
                  tx_raddr = s2ib_pkg::TX_LEN_SLOT[AW-1:0];
                  if (cmd_ff == s2ib_pkg::CMD_RD_N) begin
                     rxptr_in = '0;
                  end
               end
            end else if (op_ff == s2ib_pkg::OP_I2C_BYTE) begin
               if ((cmd_ff == s2ib_pkg::CMD_RD_N) && (8'(rxptr_ff) < DEPTH_B)) begin
                  rx_we = 1'b1;
                  rxptr_in = rxptr_ff + 1'b1;
               end
            end
         end
         s2ib_pkg::ST_LEN: begin
            len_in = (tx_rd > len_max) ? len_max[CNT_W-1:0] : tx_rd[CNT_W-1:0];
            cnt_in = '0;
            tx_re = 1'b1;
            tx_raddr = s2ib_pkg::TX_ADDR_SLOT[AW-1:0];
         end
         s2ib_pkg::ST_START: begin
            addr_in = tx_rd;
         end
         s2ib_pkg::ST_ADDR: begin
            tx_re = 1'b1;
            tx_raddr = s2ib_pkg::TX_DATA_SLOT[AW-1:0];
         end
         s2ib_pkg::ST_BODY: begin
            cnt_in = cnt_nxt;
            // prefetch the next data byte while this one goes out
            tx_re = (body_idx < DEPTH_B);
            tx_raddr = body_idx[AW-1:0];
         end
         default: ;
      endcase
   end

   // response outputs
   always_comb begin
      rsp_valid = 1'b0;
      rsp_out_kind = s2ib_pkg::OUT_SPI;
      rsp_spi_answer = 8'd0;
      rsp_i2c_kind = s2ib_pkg::I2C_START;
      rsp_i2c_byte = 8'd0;
      rsp_last = 1'b0;
      unique case (state_ff)
         s2ib_pkg::ST_SPI_ANS: begin
            rsp_valid = 1'b1;
            rsp_spi_answer = ans_rx_ff ? rx_rd : ans_ff;
            rsp_last = 1'b1;
         end
         s2ib_pkg::ST_START: begin
            rsp_valid = 1'b1;
            rsp_out_kind = s2ib_pkg::OUT_I2C;
         end
         s2ib_pkg::ST_ADDR: begin
            rsp_valid = 1'b1;
            rsp_out_kind = s2ib_pkg::OUT_I2C;
            rsp_i2c_kind = s2ib_pkg::I2C_ADR;
            rsp_i2c_byte = addr_ff;
         end
         s2ib_pkg::ST_BODY: begin
            rsp_valid = 1'b1;
            rsp_out_kind = s2ib_pkg::OUT_I2C;
            rsp_i2c_kind = rd_burst_ff ? s2ib_pkg::I2C_CLK : s2ib_pkg::I2C_DATA;
            rsp_i2c_byte = rd_burst_ff ? 8'd0 : tx_rd;
         end
         s2ib_pkg::ST_STOP: begin
            rsp_valid = 1'b1;
            rsp_out_kind = s2ib_pkg::OUT_I2C;
            rsp_i2c_kind = s2ib_pkg::I2C_STOP;
            rsp_i2c_byte = rd_burst_ff ? 8'd0 : addr_ff;
            rsp_last = 1'b1;
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != s2ib_pkg::ST_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s2ib_pkg::ST_IDLE;
         desel_ff <= 1'b0;
         step_ff <= 8'd0;
         cmd_ff <= s2ib_pkg::CMD_WR_N;
         regptr_ff <= 3'd0;
         rxptr_ff <= '0;
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= 8'd0;
         end
         tx_vld_ff <= '0;
         rx_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         desel_ff <= desel_in;
         step_ff <= step_in;
         cmd_ff <= cmd_in;
         regptr_ff <= regptr_in;
         rxptr_ff <= rxptr_in;
         regs_ff <= regs_in;
         if (tx_we) begin
            tx_vld_ff[tx_waddr] <= 1'b1;
         end
         if (rx_we) begin
            rx_vld_ff[rx_waddr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff <= req_opcode;
         data_ff <= req_data_byte;
         cs_ff <= req_cs_level;
      end
      ans_ff <= ans_in;
      ans_rx_ff <= ans_rx_in;
      len_ff <= len_in;
      cnt_ff <= cnt_in;
      addr_ff <= addr_in;
      rd_burst_ff <= rd_burst_in;
   end

   // transmit store
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_waddr] <= data_ff;
      end
      if (tx_re) begin
         tx_q_ff <= tx_mem[tx_raddr];
         tx_qv_ff <= tx_vld_ff[tx_raddr];
      end
   end

   // receive store
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_waddr] <= data_ff;
      end
      if (rx_re) begin
         rx_q_ff <= rx_mem[rx_raddr];
         rx_qv_ff <= rx_vld_ff[rx_raddr];
      end
   end

`ifndef SYNTHESIS
   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside of a busy window");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("block still busy after final response");

   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_rxptr_bound: assert property (@(posedge clock) disable iff (reset)
      8'(rxptr_ff) <= DEPTH_B)
      else $error("receive pointer past the store");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s2ib_pkg::ST_BODY) |-> (cnt_ff < len_ff))
      else $error("burst counter ran past the length");
`endif

endmodule

@@ tb/sv/spi_to_i2c_bridge_controller_unit_test.sv @@
`timescale 1ns / 1ps

module spi_to_i2c_bridge_controller_unit_test;

   localparam int BUFFER_DEPTH = 60;
   localparam int REGISTER_COUNT = 6;
   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int ITEM_TARGET = 180;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] spi_answer;
      logic [2:0] i2c_kind;
      logic [7:0] i2c_byte;
      logic       last;
   } bridge_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_opcode = s2ib_pkg::OP_SPI_BYTE;
   logic [7:0] req_data_byte = '0;
   logic       req_cs_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_out_kind;
   logic [7:0] rsp_spi_answer;
   logic [2:0] rsp_i2c_kind;
   logic [7:0] rsp_i2c_byte;
   logic       rsp_last;

   // bridge state as predicted from the accepted requests
   logic       deselected = 1'b0;
   logic [7:0] frame_pos = '0;
   logic [7:0] active_cmd = s2ib_pkg::CMD_WR_N;
   logic [7:0] tx_store [BUFFER_DEPTH];
   logic [7:0] rx_store [BUFFER_DEPTH];
   logic [7:0] reg_file [REGISTER_COUNT];
   logic [2:0] reg_ptr = '0;
   int         rx_ptr = 0;

   bridge_rsp_type pending_results [$];

   int fail_count = 0;
   int checked_count = 0;
   int request_count = 0;
   int random_count = 0;
   int burst_count = 0;
   int cycle_count = 0;
   bit no_idle = 1'b0;
   bit in_random = 1'b0;

   spi_to_i2c_bridge_controller_unit #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .REGISTER_COUNT(REGISTER_COUNT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .req_cs_level(req_cs_level),
      .rsp_valid(rsp_valid),
      .rsp_out_kind(rsp_out_kind),
      .rsp_spi_answer(rsp_spi_answer),
      .rsp_i2c_kind(rsp_i2c_kind),
      .rsp_i2c_byte(rsp_i2c_byte),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses still pending", $time, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic push_rsp(input logic kind, input logic [7:0] answer,
                           input logic [2:0] msg, input logic [7:0] msg_byte,
                           input logic last);
      bridge_rsp_type r;
      r = {kind, answer, msg, msg_byte, last};
      pending_results.push_back(r);
   endtask

   // returns ignored = 1 when the request leaves the bridge untouched
   task automatic predict_bridge(input logic [1:0] op, input logic [7:0] data,
                                 input logic cs, output bit ignored);
      logic [7:0] answer;
      logic [7:0] addr;
      logic [7:0] pos_m1;
      int len;
      int data_idx;
      bit is_write;
      ignored = 1'b0;
      case (op)
         s2ib_pkg::OP_SPI_BYTE: begin
            if (deselected) begin
               frame_pos = '0;
               ignored = 1'b1;
            end else begin
               answer = s2ib_pkg::ANSWER_IDLE;
               pos_m1 = frame_pos - 8'd1;
               if (frame_pos == 0) active_cmd = data;
               case (active_cmd)
                  s2ib_pkg::CMD_WR_N, s2ib_pkg::CMD_RD_N:
                     if (frame_pos < BUFFER_DEPTH) tx_store[frame_pos[AW-1:0]] = data;
                  s2ib_pkg::CMD_RD_BUF:
                     if (frame_pos >= 1 && frame_pos <= BUFFER_DEPTH)
                        answer = rx_store[pos_m1[AW-1:0]];
                  s2ib_pkg::CMD_WR_REG, s2ib_pkg::CMD_RD_REG: begin
                     if (frame_pos == 1) begin
                        // out of range offset keeps the old pointer
                        if (data < REGISTER_COUNT) reg_ptr = data[2:0];
                     end else if (frame_pos == 2 && reg_ptr < REGISTER_COUNT) begin
                        if (active_cmd == s2ib_pkg::CMD_WR_REG) reg_file[reg_ptr] = data;
                        else answer = reg_file[reg_ptr];
                     end
                  end
                  default: ;
               endcase
               if (frame_pos != 8'hff) frame_pos = frame_pos + 8'd1;
               push_rsp(s2ib_pkg::OUT_SPI, answer, '0, '0, 1'b1);
            end
         end
         s2ib_pkg::OP_CS_CHANGE: begin
            deselected = cs;
            frame_pos = '0;
            if (!cs) begin
               active_cmd = s2ib_pkg::CMD_NONE;
            end else if (active_cmd == s2ib_pkg::CMD_WR_N ||
                         active_cmd == s2ib_pkg::CMD_RD_N) begin
               is_write = (active_cmd == s2ib_pkg::CMD_WR_N);
               len = tx_store[s2ib_pkg::TX_LEN_SLOT[AW-1:0]];
               addr = tx_store[s2ib_pkg::TX_ADDR_SLOT[AW-1:0]];
               if (is_write && len > BUFFER_DEPTH - 3) len = BUFFER_DEPTH - 3;
               if (!is_write && len > BUFFER_DEPTH) len = BUFFER_DEPTH;
               if (!is_write) rx_ptr = 0;
               push_rsp(s2ib_pkg::OUT_I2C, '0, s2ib_pkg::I2C_START, '0, 1'b0);
               push_rsp(s2ib_pkg::OUT_I2C, '0, s2ib_pkg::I2C_ADR, addr, 1'b0);
               for (int i = 0; i < len; i++) begin
                  data_idx = s2ib_pkg::TX_DATA_SLOT + i;
                  if (is_write) push_rsp(s2ib_pkg::OUT_I2C, '0, s2ib_pkg::I2C_DATA,
                                         tx_store[data_idx[AW-1:0]], 1'b0);
                  else push_rsp(s2ib_pkg::OUT_I2C, '0, s2ib_pkg::I2C_CLK, '0, 1'b0);
               end
               // write stop repeats the address, read stop carries nothing
               push_rsp(s2ib_pkg::OUT_I2C, '0, s2ib_pkg::I2C_STOP,
                        is_write ? addr : 8'h00, 1'b1);
               burst_count++;
            end
         end
         s2ib_pkg::OP_I2C_BYTE: begin
            if (active_cmd == s2ib_pkg::CMD_RD_N && rx_ptr < BUFFER_DEPTH) begin
               rx_store[rx_ptr[AW-1:0]] = data;
               rx_ptr++;
            end else begin
               ignored = 1'b1;
            end
         end
         default: ignored = 1'b1;
      endcase
   endtask

   always @(posedge clock) begin
      bridge_rsp_type got;
      bridge_rsp_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_out_kind, rsp_spi_answer, rsp_i2c_kind, rsp_i2c_byte, rsp_last};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response kind=%0d ans=%02h msg=%0d byte=%02h last=%0d",
                     $time, got.out_kind, got.spi_answer, got.i2c_kind, got.i2c_byte,
                     got.last);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (got !== want) begin
               $display("%0t: mismatch expected kind=%0d ans=%02h msg=%0d byte=%02h last=%0d",
                        $time, want.out_kind, want.spi_answer, want.i2c_kind,
                        want.i2c_byte, want.last);
               $display("%0t:          actual   kind=%0d ans=%02h msg=%0d byte=%02h last=%0d",
                        $time, got.out_kind, got.spi_answer, got.i2c_kind,
                        got.i2c_byte, got.last);
               fail_count++;
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [7:0] data, input logic cs);
      int gap;
      int pick;
      bit ignored;
      gap = 0;
      if (!no_idle) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 3);
         else if (pick < 97) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      req_cs_level <= cs;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_bridge(op, data, cs, ignored);
      request_count++;
      if (in_random && !ignored) random_count++;
   endtask

   task automatic send_spi(input logic [7:0] data);
      send_request(s2ib_pkg::OP_SPI_BYTE, data, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_cs(input logic level);
      send_request(s2ib_pkg::OP_CS_CHANGE, 8'($urandom_range(0, 255)), level);
   endtask

   task automatic send_i2c(input logic [7:0] data);
      send_request(s2ib_pkg::OP_I2C_BYTE, data, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_after_reset();
      // command register resets to write-n, so a deselect emits an empty write
      send_cs(1'b1);
      send_i2c(8'h33);
      send_spi(8'h00);
   endtask

   task automatic test_registers();
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_WR_REG);
      send_spi(8'h05);
      send_spi(8'hff);
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_RD_REG);
      send_spi(8'h06);
      send_spi(8'h00);
      send_spi(8'h12);
   endtask

   task automatic test_transfers();
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_WR_N);
      send_spi(8'h02);
      send_spi(8'hff);
      send_spi(8'h00);
      send_spi(8'hff);
      send_cs(1'b1);
      send_cs(1'b1);
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_RD_N);
      send_spi(8'h02);
      send_spi(8'h00);
      send_cs(1'b1);
      send_i2c(8'hff);
      send_i2c(8'h00);
      send_i2c(8'ha5);
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_RD_BUF);
      send_spi(8'h00);
      send_spi(8'h00);
      send_spi(8'h00);
      send_cs(1'b0);
      send_spi(8'h7f);
      send_spi(8'h00);
      send_cs(1'b1);
   endtask

   task automatic test_store_limits();
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_WR_N);
      send_spi(8'hff);
      send_spi(8'h5c);
      // the last data byte lands one past the store end and is dropped
      for (int i = 0; i < BUFFER_DEPTH - 2; i++) send_spi(8'($urandom_range(0, 255)));
      send_cs(1'b1);
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_RD_N);
      send_spi(8'hff);
      send_spi(8'h3b);
      send_cs(1'b1);
      for (int i = 0; i < 4; i++) send_i2c(8'($urandom_range(0, 255)));
      wait_for_drain();
      send_cs(1'b0);
      send_spi(s2ib_pkg::CMD_RD_BUF);
      for (int i = 0; i < 6; i++) send_spi(8'($urandom_range(0, 255)));
      send_cs(1'b1);
   endtask

   task automatic run_random_frame();
      int pick;
      int len;
      int count;
      bit wide;
      no_idle = ($urandom_range(0, 3) == 0);
      wide = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         count = $urandom_range(1, 6);
         for (int i = 0; i < count; i++)
            send_request(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         return;
      end
      send_cs(1'b0);
      if (pick < 33) begin
         count = wide ? $urandom_range(50, 65) : $urandom_range(0, 8);
         len = ($urandom_range(0, 9) < 7) ? count : $urandom_range(0, 255);
         send_spi(s2ib_pkg::CMD_WR_N);
         send_spi(8'(len));
         send_spi(8'($urandom_range(0, 255)));
         for (int i = 0; i < count; i++) send_spi(8'($urandom_range(0, 255)));
      end else if (pick < 53) begin
         len = wide ? $urandom_range(50, 255) : $urandom_range(0, 8);
         send_spi(s2ib_pkg::CMD_RD_N);
         send_spi(8'(len));
         send_spi(8'($urandom_range(0, 255)));
         send_cs(1'b1);
         count = (len > BUFFER_DEPTH ? BUFFER_DEPTH : len) + $urandom_range(0, 2);
         for (int i = 0; i < count; i++) send_i2c(8'($urandom_range(0, 255)));
         return;
      end else if (pick < 65) begin
         count = wide ? $urandom_range(55, 66) : $urandom_range(1, 8);
         send_spi(s2ib_pkg::CMD_RD_BUF);
         for (int i = 0; i < count; i++) send_spi(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
         send_spi(($urandom_range(0, 1) == 1) ? s2ib_pkg::CMD_WR_REG : s2ib_pkg::CMD_RD_REG);
         send_spi(8'($urandom_range(0, 7)));
         send_spi(8'($urandom_range(0, 255)));
         count = $urandom_range(0, 2);
         for (int i = 0; i < count; i++) send_spi(8'($urandom_range(0, 255)));
      end else begin
         // arbitrary command byte, possibly cut short
         count = $urandom_range(0, 4);
         send_spi(8'($urandom_range(0, 255)));
         for (int i = 0; i < count; i++) send_spi(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) != 0) send_cs(1'b1);
      if ($urandom_range(0, 9) == 0) send_cs(1'b1);
   endtask

   task automatic test_random();
      in_random = 1'b1;
      while (request_count < ITEM_TARGET) run_random_frame();
      in_random = 1'b0;
      no_idle = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         tx_store[i] = '0;
         rx_store[i] = '0;
      end
      for (int i = 0; i < REGISTER_COUNT; i++) reg_file[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_registers();
      test_transfers();
      test_store_limits();
      test_random();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d requests (%0d random), checked %0d responses in %0d cycles",
               request_count, random_count, checked_count, cycle_count);
      $display("covered %0d i2c bursts, register access, buffer reads and store limits",
               burst_count);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
